[hw/rtl/rgba8_over_compositor_macros.svh]
// Assertion macros shared by the compositor RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RGBA8_OVER_COMPOSITOR_MACROS_SVH
`define RGBA8_OVER_COMPOSITOR_MACROS_SVH

`ifndef SYNTHESIS
`define R8OC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("r8oc: same-cycle check failed");
`define R8OC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("r8oc: next-cycle check failed");
`else
`define R8OC_ASSERT_IMP(lbl, ante, cons)
`define R8OC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/r8oc_pkg.sv]
// Constants and types for the RGBA8 over compositor.
// No dependencies; used by the interfaces and every module.
package r8oc_pkg;

  localparam int CH_W        = 8;
  localparam int CH_MAX      = 255;
  localparam int ALPHA_ROUND = 127;
  localparam int NUM_COL     = 3;
  localparam int NUM_LANES   = NUM_COL + 1;   // three colours, then alpha
  localparam int ALPHA_LANE  = NUM_COL;
  localparam int PROD_W      = 2 * CH_W;      // one channel times one alpha
  localparam int W_W         = PROD_W + 1;    // weight, up to 65025
  localparam int DVD_W       = 3 * CH_W;      // colour dividend, up to 255*W + W/2
  localparam int Q_W         = CH_W;
  localparam int STEP_BITS   = 2;             // quotient bits resolved per divider stage
  localparam int DIV_STAGES  = Q_W / STEP_BITS;

  typedef struct packed {
    logic [DVD_W-1:0] rem;
    logic [W_W-1:0]   dsr;
    logic [Q_W-1:0]   q;
  } r8oc_lane_t;

  typedef struct packed {
    r8oc_lane_t [NUM_LANES-1:0] lane;
    logic                       zero;
  } r8oc_div_t;

endpackage

[hw/rtl/r8oc_if.sv]
// Valid/ready channels of the compositor: pixel pair in, pixel out.
// Depends on r8oc_pkg for the channel width.
interface r8oc_pair_if
  import r8oc_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] src_red;
  logic [CH_W-1:0] src_green;
  logic [CH_W-1:0] src_blue;
  logic [CH_W-1:0] src_alpha;
  logic [CH_W-1:0] dst_red;
  logic [CH_W-1:0] dst_green;
  logic [CH_W-1:0] dst_blue;
  logic [CH_W-1:0] dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

interface r8oc_pix_if
  import r8oc_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

[hw/rtl/r8oc_front.sv]
// Front end: products and weight, then dividends and divisors for the divider.
// Depends on r8oc_pkg, r8oc_if and the assertion macros.
`include "rgba8_over_compositor_macros.svh"

module r8oc_front
  import r8oc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  r8oc_pair_if.sink   in_pix,
  output logic        valid_o,
  input  logic        ready_i,
  output r8oc_div_t   data_o
);

  // stage 1: products and weight
  logic                  v1_r;
  logic [PROD_W-1:0]     ps_r [NUM_COL];
  logic [PROD_W-1:0]     pd_r [NUM_COL];
  logic [CH_W-1:0]       inv_r;
  logic [W_W-1:0]        w_r;
  logic [PROD_W-1:0]     ps_nxt [NUM_COL];
  logic [PROD_W-1:0]     pd_nxt [NUM_COL];
  logic [CH_W-1:0]       inv_nxt;
  logic [W_W-1:0]        w_nxt;
  logic [CH_W-1:0]       sc [NUM_COL];
  logic [CH_W-1:0]       dc [NUM_COL];
  logic                  rdy1;

  // stage 2: dividends
  logic                  v2_r;
  r8oc_div_t             d2_r;
  r8oc_div_t             d2_nxt;
  logic                  rdy2;

  assign rdy2         = !v2_r || ready_i;
  assign rdy1         = !v1_r || rdy2;
  assign in_pix.ready = rdy1;
  assign valid_o      = v2_r;
  assign data_o       = d2_r;

  assign sc[0] = in_pix.src_red;
  assign sc[1] = in_pix.src_green;
  assign sc[2] = in_pix.src_blue;
  assign dc[0] = in_pix.dst_red;
  assign dc[1] = in_pix.dst_green;
  assign dc[2] = in_pix.dst_blue;

  always_comb begin
    inv_nxt = CH_W'(CH_MAX) - in_pix.src_alpha;
    for (int k = 0; k < NUM_COL; k++) begin
      ps_nxt[k] = PROD_W'(sc[k]) * PROD_W'(in_pix.src_alpha);
      pd_nxt[k] = PROD_W'(dc[k]) * PROD_W'(in_pix.dst_alpha);
    end
    // sa*255 as a shift and subtract
    w_nxt = (W_W'(in_pix.src_alpha) << CH_W) - W_W'(in_pix.src_alpha)
          + W_W'(PROD_W'(in_pix.dst_alpha) * PROD_W'(inv_nxt));
  end

  always_comb begin
    logic [DVD_W-1:0] hi;
    logic [DVD_W-1:0] lo;
    d2_nxt.zero = (w_r == '0);
    for (int k = 0; k < NUM_COL; k++) begin
      hi = (DVD_W'(ps_r[k]) << CH_W) - DVD_W'(ps_r[k]);
      lo = DVD_W'(pd_r[k]) * DVD_W'(inv_r);
      d2_nxt.lane[k].rem = hi + lo + DVD_W'(w_r >> 1);
      d2_nxt.lane[k].dsr = w_r;
      d2_nxt.lane[k].q   = '0;
    end
    d2_nxt.lane[ALPHA_LANE].rem = DVD_W'(w_r) + DVD_W'(ALPHA_ROUND);
    d2_nxt.lane[ALPHA_LANE].dsr = W_W'(CH_MAX);
    d2_nxt.lane[ALPHA_LANE].q   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_pix.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_pix.valid) begin
      ps_r  <= ps_nxt;
      pd_r  <= pd_nxt;
      inv_r <= inv_nxt;
      w_r   <= w_nxt;
    end
    if (rdy2 && v1_r) begin
      d2_r <= d2_nxt;
    end
  end

  `R8OC_ASSERT_IMP(a_zero_weight_no_colour, v2_r && d2_r.zero, d2_r.lane[0].rem == '0 && d2_r.lane[1].rem == '0 && d2_r.lane[2].rem == '0)
  `R8OC_ASSERT_IMP(a_live_weight_floor, v2_r && !d2_r.zero, d2_r.lane[0].dsr >= W_W'(CH_MAX))
  `R8OC_ASSERT_IMP(a_empty_stage_takes, !v1_r, in_pix.ready)

endmodule

[hw/rtl/r8oc_div_stage.sv]
// One stage of the restoring divider: resolves STEP_BITS quotient bits per lane.
// Depends on r8oc_pkg and the assertion macros.
`include "rgba8_over_compositor_macros.svh"

module r8oc_div_stage
  import r8oc_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_i,
  output logic      ready_o,
  input  r8oc_div_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output r8oc_div_t data_o
);

  localparam int TOP_BIT  = Q_W - 1 - STAGE * STEP_BITS;
  localparam int LAST_BIT = TOP_BIT - STEP_BITS + 1;

  logic      v_r;
  r8oc_div_t d_r;
  r8oc_div_t d_nxt;

  assign ready_o = !v_r || ready_i;
  assign valid_o = v_r;
  assign data_o  = d_r;

  always_comb begin
    logic [DVD_W-1:0] trial;
    d_nxt = data_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int j = 0; j < STEP_BITS; j++) begin
        trial = DVD_W'(data_i.lane[l].dsr) << (TOP_BIT - j);
        // zero weight: leave the quotient clear
        if (!data_i.zero && d_nxt.lane[l].rem >= trial) begin
          d_nxt.lane[l].rem           = d_nxt.lane[l].rem - trial;
          d_nxt.lane[l].q[TOP_BIT - j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      d_r <= d_nxt;
    end
  end

  `R8OC_ASSERT_IMP(a_rem_bound_colour, v_r && !d_r.zero, d_r.lane[0].rem < (DVD_W'(d_r.lane[0].dsr) << LAST_BIT))
  `R8OC_ASSERT_IMP(a_rem_bound_alpha, v_r && !d_r.zero, d_r.lane[ALPHA_LANE].rem < (DVD_W'(d_r.lane[ALPHA_LANE].dsr) << LAST_BIT))
  `R8OC_ASSERT_NXT(a_stall_holds_quotient, v_r && !ready_i, v_r && $stable(d_r.lane[0].q) && $stable(d_r.lane[ALPHA_LANE].q))

endmodule

[hw/rtl/rgba8_over_compositor.sv]
// Top level of the RGBA8 over compositor: front end, divider pipeline, output register.
// Depends on r8oc_pkg, r8oc_if, r8oc_front and r8oc_div_stage.
// Composites one unpremultiplied RGBA8 source pixel over one destination pixel per
// transaction. A pixel pair can be taken every cycle unless back-pressure has filled the
// pipeline. Two multiply stages form the weight and dividends, four divider stages each
// resolve two quotient bits of every channel (alpha is divided by 255 in its own lane of the
// same stages), and one output register holds the result. Each stage has its own valid bit
// and advances whenever the stage after it is empty or moving, so bubbles close up under
// back-pressure. Zero weight (both alphas zero) gives an all-zero pixel.
`include "rgba8_over_compositor_macros.svh"

module rgba8_over_compositor
  import r8oc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  r8oc_pair_if.sink   in_pix,
  r8oc_pix_if.source  out_pix
);

  logic      stg_v   [DIV_STAGES+1];
  logic      stg_rdy [DIV_STAGES+1];
  r8oc_div_t stg_d   [DIV_STAGES+1];

  logic            out_v_r;
  logic [CH_W-1:0] red_r;
  logic [CH_W-1:0] green_r;
  logic [CH_W-1:0] blue_r;
  logic [CH_W-1:0] alpha_r;

  r8oc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .valid_o (stg_v[0]),
    .ready_i (stg_rdy[0]),
    .data_o  (stg_d[0])
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    r8oc_div_stage #(
      .STAGE (s)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (stg_v[s]),
      .ready_o (stg_rdy[s]),
      .data_i  (stg_d[s]),
      .valid_o (stg_v[s+1]),
      .ready_i (stg_rdy[s+1]),
      .data_o  (stg_d[s+1])
    );
  end

  assign stg_rdy[DIV_STAGES] = !out_v_r || out_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (stg_rdy[DIV_STAGES]) begin
      out_v_r <= stg_v[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[DIV_STAGES] && stg_v[DIV_STAGES]) begin
      red_r   <= stg_d[DIV_STAGES].lane[0].q;
      green_r <= stg_d[DIV_STAGES].lane[1].q;
      blue_r  <= stg_d[DIV_STAGES].lane[2].q;
      alpha_r <= stg_d[DIV_STAGES].lane[ALPHA_LANE].q;
    end
  end

  assign out_pix.valid     = out_v_r;
  assign out_pix.out_red   = red_r;
  assign out_pix.out_green = green_r;
  assign out_pix.out_blue  = blue_r;
  assign out_pix.out_alpha = alpha_r;

  `R8OC_ASSERT_IMP(a_clear_alpha_clear_colour, out_pix.valid && out_pix.out_alpha == '0, out_pix.out_red == '0 && out_pix.out_green == '0 && out_pix.out_blue == '0)
  `R8OC_ASSERT_IMP(a_backpressure_only_when_full, !in_pix.ready, out_pix.valid && !out_pix.ready && stg_v[DIV_STAGES] && stg_v[0])
  `R8OC_ASSERT_NXT(a_last_stage_moves_out, stg_v[DIV_STAGES] && stg_rdy[DIV_STAGES], out_pix.valid)

endmodule
